// File: src/tae_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tae_pkg
// shared types, constants and character codes of the tab and escape expander
// ----------------------------------------------------------------------------
package tae_pkg;

  // widest tab stop distance, and the widths that follow from it
  localparam int unsigned MAX_TAB_WIDTH = 32;
  localparam int unsigned COL_W         = $clog2(MAX_TAB_WIDTH);
  localparam int unsigned W_W           = COL_W + 1;

  // configuration port
  localparam int unsigned TW_W      = 6;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = TW_W;

  localparam logic [TW_W-1:0] TAB_WIDTH_RST   = TW_W'(8);
  localparam logic            ESCAPE_MODE_RST = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAB_WIDTH   = 1'b0,
    REG_ESCAPE_MODE = 1'b1
  } cfg_reg_e;

  // character codes
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_LF      = 8'd10;
  localparam logic [7:0] CH_CR      = 8'd13;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_BSLASH  = 8'd92;
  localparam logic [7:0] CH_LOWER_N = 8'd110;
  localparam logic [7:0] CH_LOWER_T = 8'd116;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_PRE_BS,
    S_SPACES,
    S_CHAR,
    S_CR,
    S_LF,
    S_POST_BS
  } state_e;

  // main run of one beat
  typedef enum logic [1:0] {
    MAIN_NONE,
    MAIN_SPACES,
    MAIN_CHAR,
    MAIN_CRLF
  } main_e;

  // column unit operations
  typedef enum logic {
    COL_INC,
    COL_REDUCE
  } col_op_e;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             flag;
  } col_res_t;

endpackage : tae_pkg
`default_nettype wire

// File: src/tae_col_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tae_col_unit
// shared column unit: increment with wrap at the tab width, or one step of
// reduction of the column modulo the tab width
// ----------------------------------------------------------------------------
module tae_col_unit (
  input  wire tae_pkg::col_op_e        op_i,
  input  wire logic [tae_pkg::COL_W-1:0] col_i,
  input  wire logic [tae_pkg::W_W-1:0]   width_i,
  output tae_pkg::col_res_t            res_o
);

  logic [tae_pkg::W_W-1:0] col_ext;
  logic [tae_pkg::W_W-1:0] sum;
  logic [tae_pkg::W_W-1:0] diff;
  logic                    ge;

  assign col_ext = {1'b0, col_i};
  assign sum     = col_ext + tae_pkg::W_W'(1);
  assign diff    = col_ext - width_i;
  assign ge      = (col_ext >= width_i);

  always_comb begin
    res_o = '0;
    case (op_i)
      tae_pkg::COL_INC: begin
        // flag marks the wrap onto a tab stop
        res_o.flag = (sum == width_i);
        res_o.col  = res_o.flag ? '0 : sum[tae_pkg::COL_W-1:0];
      end
      tae_pkg::COL_REDUCE: begin
        // flag marks that a subtraction was still needed
        res_o.flag = ge;
        res_o.col  = ge ? diff[tae_pkg::COL_W-1:0] : col_i;
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

endmodule : tae_col_unit
`default_nettype wire

// File: src/tab_and_escape_expander.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tab_and_escape_expander
// expands tabs to spaces up to the next tab stop and translates backslash
// escapes, one input character in, a run of output characters out
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+----------------------------
//   cfg      | in        | cfg_we_i              | cfg_index_i, cfg_data_i
//   in       | in        | in_valid_i/in_ready_o | char_in_i, end_of_text_i
//   out      | out       | out_valid_o/out_ready_i | char_out_o, run_last_o,
//            |           |                       | text_last_o
//
// an input beat is accepted in the idle state, its column checked in the reduce
// state, and then its output beats follow one per cycle while the output is not
// stalled; the emit loop steps the column through the shared column unit
// after a change of tab width the column check repeats its subtraction of the
// width from the stored column until the column lies below the width
// reset brings tab width 8, escape mode on, column 0 and no pending backslash
// a stalled output holds the sequencer in its emit states; the input is taken only when idle
// ----------------------------------------------------------------------------
module tab_and_escape_expander (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,

  input  wire logic                            cfg_we_i,
  input  wire logic [tae_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [tae_pkg::CFG_DAT_W-1:0]   cfg_data_i,

  input  wire logic                            in_valid_i,
  output      logic                            in_ready_o,
  input  wire logic [7:0]                      char_in_i,
  input  wire logic                            end_of_text_i,

  output      logic                            out_valid_o,
  input  wire logic                            out_ready_i,
  output      logic [7:0]                      char_out_o,
  output      logic                            run_last_o,
  output      logic                            text_last_o
);

  // configuration registers
  logic [tae_pkg::TW_W-1:0] tab_width_q;
  logic                     escape_mode_q;

  // sequencer and line state
  tae_pkg::state_e          state_q, state_d;
  logic [tae_pkg::COL_W-1:0] col_q, col_d;
  logic                     held_q, held_d;   // escape backslash pending
  logic                     abs_q, abs_d;     // plain backslash just emitted

  // latched beat and its plan
  logic [7:0]               ch_q, ch_d;
  logic                     eot_q, eot_d;
  logic [tae_pkg::W_W-1:0]  w_q, w_d;
  tae_pkg::main_e           main_q, main_d;
  logic                     post_q, post_d;
  logic                     col_one_q, col_one_d;

  // output register
  logic                     out_valid_q, out_valid_d;
  logic [7:0]               out_char_q, out_char_d;
  logic                     out_run_last_q, out_run_last_d;
  logic                     out_text_last_q, out_text_last_d;

  // shared column unit
  tae_pkg::col_op_e         col_op;
  tae_pkg::col_res_t        col_res;

  logic [tae_pkg::W_W-1:0]  eff_width;
  logic                     can_emit;
  logic                     is_t, is_n, is_tab, is_bs, is_lf;

  // plan decided in the column check cycle
  logic                     plan_pre;
  tae_pkg::main_e           plan_main;
  logic                     plan_held;

  // ------------------------------------------------------------------------
  // configuration writes
  // ------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tab_width_q   <= tae_pkg::TAB_WIDTH_RST;
      escape_mode_q <= tae_pkg::ESCAPE_MODE_RST;
    end else if (cfg_we_i) begin
      unique case (tae_pkg::cfg_reg_e'(cfg_index_i))
        tae_pkg::REG_TAB_WIDTH:   tab_width_q   <= cfg_data_i[tae_pkg::TW_W-1:0];
        tae_pkg::REG_ESCAPE_MODE: escape_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // tab width clamped into 1..MAX_TAB_WIDTH
  always_comb begin
    if (tab_width_q == '0) begin
      eff_width = tae_pkg::W_W'(1);
    end else if ({{tae_pkg::W_W{1'b0}}, tab_width_q} >
                 (tae_pkg::W_W + tae_pkg::TW_W)'(tae_pkg::MAX_TAB_WIDTH)) begin
      eff_width = tae_pkg::W_W'(tae_pkg::MAX_TAB_WIDTH);
    end else begin
      eff_width = tae_pkg::W_W'(tab_width_q);
    end
  end

  // ------------------------------------------------------------------------
  // column unit: reduction during the check cycle, increment otherwise
  // ------------------------------------------------------------------------
  assign col_op = (state_q == tae_pkg::S_REDUCE) ? tae_pkg::COL_REDUCE : tae_pkg::COL_INC;

  tae_col_unit u_col (
    .op_i    (col_op),
    .col_i   (col_q),
    .width_i (w_q),
    .res_o   (col_res)
  );

  assign is_t   = (ch_q == tae_pkg::CH_LOWER_T);
  assign is_n   = (ch_q == tae_pkg::CH_LOWER_N);
  assign is_tab = (ch_q == tae_pkg::CH_TAB);
  assign is_bs  = (ch_q == tae_pkg::CH_BSLASH);
  assign is_lf  = (ch_q == tae_pkg::CH_LF);

  // first state of the main run, or what follows when there is none
  function automatic tae_pkg::state_e main_entry(tae_pkg::main_e m, logic post);
    tae_pkg::state_e s;
    case (m)
      tae_pkg::MAIN_SPACES: s = tae_pkg::S_SPACES;
      tae_pkg::MAIN_CHAR:   s = tae_pkg::S_CHAR;
      tae_pkg::MAIN_CRLF:   s = tae_pkg::S_CR;
      default:              s = post ? tae_pkg::S_POST_BS : tae_pkg::S_IDLE;
    endcase
    return s;
  endfunction

  // what the beat makes of its character
  always_comb begin
    plan_pre  = 1'b0;
    plan_main = tae_pkg::MAIN_CHAR;
    plan_held = 1'b0;
    if (held_q && is_t) begin
      // backslash-t expands like a tab
      plan_main = tae_pkg::MAIN_SPACES;
    end else if (held_q && is_n) begin
      // backslash-n becomes cr lf
      plan_main = tae_pkg::MAIN_CRLF;
    end else if (!held_q && abs_q && is_n) begin
      // plain backslash then n: copied, column lands on 1 (0 at tab width 1)
      plan_main = tae_pkg::MAIN_CHAR;
    end else begin
      // any other held backslash goes out ahead of the character
      plan_pre = held_q;
      if (is_tab) begin
        plan_main = tae_pkg::MAIN_SPACES;
      end else if (escape_mode_q && is_bs) begin
        plan_main = tae_pkg::MAIN_NONE;
        plan_held = 1'b1;
      end else begin
        plan_main = tae_pkg::MAIN_CHAR;
      end
    end
  end

  assign can_emit = !out_valid_q || out_ready_i;

  // ------------------------------------------------------------------------
  // sequencer
  // ------------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    col_d     = col_q;
    held_d    = held_q;
    abs_d     = abs_q;
    ch_d      = ch_q;
    eot_d     = eot_q;
    w_d       = w_q;
    main_d    = main_q;
    post_d    = post_q;
    col_one_d = col_one_q;

    out_valid_d     = out_valid_q && !out_ready_i;
    out_char_d      = out_char_q;
    out_run_last_d  = out_run_last_q;
    out_text_last_d = out_text_last_q;

    in_ready_o = (state_q == tae_pkg::S_IDLE);

    unique case (state_q)
      tae_pkg::S_IDLE: begin
        if (in_valid_i) begin
          ch_d    = char_in_i;
          eot_d   = end_of_text_i;
          w_d     = eff_width;
          state_d = tae_pkg::S_REDUCE;
        end
      end

      tae_pkg::S_REDUCE: begin
        if (col_res.flag) begin
          // stored column still at or past the width: take it off once more
          col_d = col_res.col;
        end else begin
          main_d    = plan_main;
          post_d    = eot_q && plan_held;
          col_one_d = !held_q && abs_q && is_n;
          held_d    = plan_held && !eot_q;
          abs_d     = 1'b0;
          state_d   = plan_pre ? tae_pkg::S_PRE_BS
                               : main_entry(plan_main, eot_q && plan_held);
        end
      end

      tae_pkg::S_PRE_BS: begin
        if (can_emit) begin
          out_valid_d    = 1'b1;
          out_char_d     = tae_pkg::CH_BSLASH;
          out_run_last_d = (main_q == tae_pkg::MAIN_NONE) && !post_q;
          col_d          = col_res.col;
          state_d        = main_entry(main_q, post_q);
        end
      end

      tae_pkg::S_SPACES: begin
        if (can_emit) begin
          out_valid_d    = 1'b1;
          out_char_d     = tae_pkg::CH_SPACE;
          out_run_last_d = col_res.flag && !post_q;
          col_d          = col_res.col;
          if (col_res.flag) begin
            state_d = post_q ? tae_pkg::S_POST_BS : tae_pkg::S_IDLE;
          end
        end
      end

      tae_pkg::S_CHAR: begin
        if (can_emit) begin
          out_valid_d    = 1'b1;
          out_char_d     = ch_q;
          out_run_last_d = !post_q;
          abs_d          = is_bs;
          if (is_lf) begin
            col_d = '0;
          end else if (col_one_q) begin
            col_d = (w_q == tae_pkg::W_W'(1)) ? '0 : tae_pkg::COL_W'(1);
          end else begin
            col_d = col_res.col;
          end
          state_d = post_q ? tae_pkg::S_POST_BS : tae_pkg::S_IDLE;
        end
      end

      tae_pkg::S_CR: begin
        if (can_emit) begin
          out_valid_d    = 1'b1;
          out_char_d     = tae_pkg::CH_CR;
          out_run_last_d = 1'b0;
          state_d        = tae_pkg::S_LF;
        end
      end

      tae_pkg::S_LF: begin
        if (can_emit) begin
          out_valid_d    = 1'b1;
          out_char_d     = tae_pkg::CH_LF;
          out_run_last_d = !post_q;
          col_d          = '0;
          state_d        = post_q ? tae_pkg::S_POST_BS : tae_pkg::S_IDLE;
        end
      end

      tae_pkg::S_POST_BS: begin
        // backslash left pending at end of text
        if (can_emit) begin
          out_valid_d    = 1'b1;
          out_char_d     = tae_pkg::CH_BSLASH;
          out_run_last_d = 1'b1;
          state_d        = tae_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = tae_pkg::S_IDLE;
      end
    endcase

    // text_last only moves together with a new output beat
    if (can_emit && out_valid_d) begin
      out_text_last_d = out_run_last_d && eot_q;
    end

    // end of text: next text starts from a clean line
    if ((state_q != tae_pkg::S_IDLE) && (state_d == tae_pkg::S_IDLE) && eot_q) begin
      col_d  = '0;
      held_d = 1'b0;
      abs_d  = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tae_pkg::S_IDLE;
      col_q       <= '0;
      held_q      <= 1'b0;
      abs_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      held_q      <= held_d;
      abs_q       <= abs_d;
      out_valid_q <= out_valid_d;
    end
  end

  // beat payload and plan
  always_ff @(posedge clk_i) begin
    ch_q            <= ch_d;
    eot_q           <= eot_d;
    w_q             <= w_d;
    main_q          <= main_d;
    post_q          <= post_d;
    col_one_q       <= col_one_d;
    out_char_q      <= out_char_d;
    out_run_last_q  <= out_run_last_d;
    out_text_last_q <= out_text_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign char_out_o  = out_char_q;
  assign run_last_o  = out_run_last_q;
  assign text_last_o = out_text_last_q;

endmodule : tab_and_escape_expander
`default_nettype wire
